[design/fluc_pkg.sv]
// shared types, codes and constant tables for the free-look camera update block
package fluc_pkg;

  // default formats
  localparam int DIR_FRAC_BITS_DEF = 30;
  localparam int POS_FRAC_BITS_DEF = 16;

  // sequencing lengths
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_FRAC  = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  // beat widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 384;

  // command kinds
  localparam logic [2:0] KIND_PITCH = 3'd0;
  localparam logic [2:0] KIND_YAW   = 3'd1;
  localparam logic [2:0] KIND_ROLL  = 3'd2;
  localparam logic [2:0] KIND_FWD   = 3'd3;
  localparam logic [2:0] KIND_RIGHT = 3'd4;
  localparam logic [2:0] KIND_UP    = 3'd5;

  // vector register selects
  localparam logic [1:0] VEC_VIEW  = 2'd0;
  localparam logic [1:0] VEC_RIGHT = 2'd1;
  localparam logic [1:0] VEC_UP    = 2'd2;
  localparam logic [1:0] VEC_T     = 2'd3;

  // second multiplier operand source
  localparam logic [1:0] B_VEC  = 2'd0;
  localparam logic [1:0] B_COS  = 2'd1;
  localparam logic [1:0] B_SIN  = 2'd2;
  localparam logic [1:0] B_DIST = 2'd3;

  // datapath actions
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_LOAD      = 4'd1;
  localparam logic [3:0] ACT_CORDIC    = 4'd2;
  localparam logic [3:0] ACT_CS_FIN    = 4'd3;
  localparam logic [3:0] ACT_SAVE      = 4'd4;
  localparam logic [3:0] ACT_MIX       = 4'd5;
  localparam logic [3:0] ACT_SQACC     = 4'd6;
  localparam logic [3:0] ACT_SQ_INIT   = 4'd7;
  localparam logic [3:0] ACT_SQ_STEP   = 4'd8;
  localparam logic [3:0] ACT_DIV_INIT  = 4'd9;
  localparam logic [3:0] ACT_DIV_STEP  = 4'd10;
  localparam logic [3:0] ACT_DIV_WRITE = 4'd11;
  localparam logic [3:0] ACT_CROSS     = 4'd12;
  localparam logic [3:0] ACT_MOVE      = 4'd13;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec3_t;

  typedef struct packed {
    logic [3:0] act;
    logic [1:0] a_vec;
    logic [1:0] a_comp;
    logic [1:0] b_src;
    logic [1:0] b_vec;
    logic [1:0] b_comp;
    logic [1:0] comp;
    logic [1:0] dst_vec;
    logic       sub;
    logic       neg;
    logic [4:0] step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
  } sts_t;

  // component read
  function automatic logic signed [31:0] pick(input vec3_t v, input logic [1:0] c);
    logic signed [31:0] r;
    unique case (c)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  // component write
  function automatic vec3_t place(input vec3_t v, input logic [1:0] c,
                                  input logic signed [31:0] val);
    vec3_t r;
    r = v;
    unique case (c)
      2'd0:    r.x = val;
      2'd1:    r.y = val;
      default: r.z = val;
    endcase
    return r;
  endfunction

  // cyclic component successors for cross products
  function automatic logic [1:0] comp_succ1(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic logic [1:0] comp_succ2(input logic [1:0] c);
    return (c == 2'd0) ? 2'd2 : c - 2'd1;
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -68'sh0_0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // arctangent table in 2^-32 turn units
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A2F;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028B;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000A2;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[design/fluc_ctrl.sv]
// sequencer that walks the datapath through rotate and move commands
module fluc_ctrl
  import fluc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] in_kind,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CORDIC  = 4'd1;
  localparam logic [3:0] ST_CSFIN   = 4'd2;
  localparam logic [3:0] ST_MIX     = 4'd3;
  localparam logic [3:0] ST_SQINIT  = 4'd4;
  localparam logic [3:0] ST_SQRT    = 4'd5;
  localparam logic [3:0] ST_DIVINIT = 4'd6;
  localparam logic [3:0] ST_DIVSTEP = 4'd7;
  localparam logic [3:0] ST_DIVWR   = 4'd8;
  localparam logic [3:0] ST_CROSS   = 4'd9;
  localparam logic [3:0] ST_MOVE    = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  logic [3:0] state;
  logic [1:0] comp;
  logic [2:0] phase;
  logic [4:0] step;
  logic [2:0] kind;

  logic [1:0] mix_a, mix_b, mix_dst, crs_a, crs_b, crs_dst, mov_vec;
  logic       mix_sub, crs_neg;
  logic       take;

  assign in_ready = (state == ST_IDLE);
  assign take     = in_valid && in_ready;

  // operand roles per command kind
  always_comb begin
    mix_a   = VEC_VIEW;
    mix_b   = VEC_UP;
    mix_sub = 1'b0;
    mix_dst = VEC_VIEW;
    crs_a   = VEC_VIEW;
    crs_b   = VEC_RIGHT;
    crs_neg = 1'b1;
    crs_dst = VEC_UP;
    mov_vec = VEC_VIEW;
    unique case (kind)
      KIND_YAW: begin
        mix_b   = VEC_RIGHT;
        mix_sub = 1'b1;
        crs_b   = VEC_UP;
        crs_neg = 1'b0;
        crs_dst = VEC_RIGHT;
      end
      KIND_ROLL: begin
        mix_a   = VEC_RIGHT;
        mix_dst = VEC_RIGHT;
      end
      KIND_RIGHT: mov_vec = VEC_RIGHT;
      KIND_UP:    mov_vec = VEC_UP;
      default: ;
    endcase
  end

  // command decode
  always_comb begin
    cmd      = '0;
    cmd.step = step;
    cmd.comp = comp;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.act = ACT_LOAD;
          cmd.neg = (in_kind == KIND_FWD);
        end
      end
      ST_CORDIC: cmd.act = ACT_CORDIC;
      ST_CSFIN:  cmd.act = ACT_CS_FIN;
      ST_MIX: begin
        cmd.sub = mix_sub;
        unique case (phase)
          3'd0: begin
            cmd.a_vec  = mix_a;
            cmd.a_comp = comp;
            cmd.b_src  = B_COS;
          end
          3'd1: begin
            cmd.a_vec  = mix_b;
            cmd.a_comp = comp;
            cmd.b_src  = B_SIN;
            cmd.act    = ACT_SAVE;
          end
          3'd2: cmd.act = ACT_MIX;
          3'd3: begin
            cmd.a_vec  = VEC_T;
            cmd.a_comp = comp;
            cmd.b_src  = B_VEC;
            cmd.b_vec  = VEC_T;
            cmd.b_comp = comp;
          end
          default: cmd.act = ACT_SQACC;
        endcase
      end
      ST_SQINIT:  cmd.act = ACT_SQ_INIT;
      ST_SQRT:    cmd.act = ACT_SQ_STEP;
      ST_DIVINIT: cmd.act = ACT_DIV_INIT;
      ST_DIVSTEP: cmd.act = ACT_DIV_STEP;
      ST_DIVWR: begin
        cmd.act     = ACT_DIV_WRITE;
        cmd.dst_vec = mix_dst;
      end
      ST_CROSS: begin
        cmd.b_src   = B_VEC;
        cmd.a_vec   = crs_a;
        cmd.b_vec   = crs_b;
        cmd.neg     = crs_neg;
        cmd.dst_vec = crs_dst;
        unique case (phase)
          3'd0: begin
            cmd.a_comp = comp_succ1(comp);
            cmd.b_comp = comp_succ2(comp);
          end
          3'd1: begin
            cmd.a_comp = comp_succ2(comp);
            cmd.b_comp = comp_succ1(comp);
            cmd.act    = ACT_SAVE;
          end
          default: cmd.act = ACT_CROSS;
        endcase
      end
      ST_MOVE: begin
        cmd.a_vec  = mov_vec;
        cmd.a_comp = comp;
        cmd.b_src  = B_DIST;
        if (phase != 3'd0) cmd.act = ACT_MOVE;
      end
      ST_DONE:  cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      comp      <= 2'd0;
      phase     <= 3'd0;
      step      <= 5'd0;
      kind      <= KIND_PITCH;
      out_valid <= 1'b0;
    end else begin
      // result beat handshake
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            kind  <= in_kind;
            comp  <= 2'd0;
            phase <= 3'd0;
            step  <= 5'd0;
            if (in_kind == KIND_PITCH || in_kind == KIND_YAW || in_kind == KIND_ROLL)
              state <= ST_CORDIC;
            else if (in_kind == KIND_FWD || in_kind == KIND_RIGHT || in_kind == KIND_UP)
              state <= ST_MOVE;
            else
              state <= ST_DONE;
          end
        end
        ST_CORDIC: begin
          step <= step + 5'd1;
          if (step == 5'(CORDIC_STEPS - 1)) state <= ST_CSFIN;
        end
        ST_CSFIN: state <= ST_MIX;
        ST_MIX: begin
          if (phase == 3'd4) begin
            phase <= 3'd0;
            comp  <= comp_succ1(comp);
            if (comp == 2'd2) state <= ST_SQINIT;
          end else begin
            phase <= phase + 3'd1;
          end
        end
        ST_SQINIT: begin
          step  <= 5'd0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          step <= step + 5'd1;
          if (step == 5'(SQRT_STEPS - 1)) begin
            comp  <= 2'd0;
            state <= sts.n_zero ? ST_CROSS : ST_DIVINIT;
          end
        end
        ST_DIVINIT: begin
          step  <= 5'd0;
          state <= ST_DIVSTEP;
        end
        ST_DIVSTEP: begin
          step <= step + 5'd1;
          if (step == 5'(DIV_STEPS - 1)) state <= ST_DIVWR;
        end
        ST_DIVWR: begin
          comp <= comp_succ1(comp);
          state <= (comp == 2'd2) ? ST_CROSS : ST_DIVINIT;
        end
        ST_CROSS: begin
          if (phase == 3'd2) begin
            phase <= 3'd0;
            comp  <= comp_succ1(comp);
            if (comp == 2'd2) state <= ST_DONE;
          end else begin
            phase <= phase + 3'd1;
          end
        end
        ST_MOVE: begin
          if (phase != 3'd0) begin
            phase <= 3'd0;
            comp  <= comp_succ1(comp);
            if (comp == 2'd2) state <= ST_DONE;
          end else begin
            phase <= 3'd1;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/fluc_dp.sv]
// camera state registers, shared multiplier, cordic, square root and divider
module fluc_dp
  import fluc_pkg::*;
#(
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [IN_DATA_W-1:0]  in_data,
  output sts_t                  sts,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int CS_SH = CORDIC_FRAC - DIR_FRAC_BITS;
  localparam logic signed [67:0] DIR_HALF = 68'sd1 <<< (DIR_FRAC_BITS - 1);
  localparam logic signed [33:0] CS_HALF  = 34'((64'd1 << CS_SH) >> 1);
  localparam logic signed [31:0] DIR_ONE  = 32'(64'd1 << DIR_FRAC_BITS);
  localparam logic signed [31:0] POS_INIT = 32'(64'd100 << POS_FRAC_BITS);
  localparam logic signed [33:0] QUARTER  = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;

  vec3_t pos, view, right, up, tv;
  logic signed [65:0] prod, acc;
  logic signed [32:0] move_dist;
  logic signed [33:0] cx, cy, cz;
  logic               cneg;
  logic signed [31:0] cs_c, cs_s;
  logic [63:0] n2, sq_n, sq_res, sq_bit;
  logic [63:0] rem, dv;
  logic [30:0] quo;
  logic        dsat, dneg;

  logic signed [31:0] opa32, opb32;
  logic signed [32:0] opa, opb;
  logic signed [67:0] comb_sum, rnd_val;
  logic signed [31:0] comb_sat, move_val, tcur, div_val, cross_val;
  logic signed [33:0] xs, ys, at, z_in, xf, yf;
  logic signed [31:0] z32;
  logic [63:0] sq_try, num;
  logic [31:0] mag;
  vec3_t dst_cur, dst_new;

  function automatic vec3_t sel_vec(input vec3_t a, input vec3_t b, input vec3_t c,
                                    input vec3_t d, input logic [1:0] s);
    vec3_t r;
    unique case (s)
      VEC_VIEW:  r = a;
      VEC_RIGHT: r = b;
      VEC_UP:    r = c;
      default:   r = d;
    endcase
    return r;
  endfunction

  // multiplier operands
  always_comb begin
    opa32 = pick(sel_vec(view, right, up, tv, cmd.a_vec), cmd.a_comp);
    opb32 = pick(sel_vec(view, right, up, tv, cmd.b_vec), cmd.b_comp);
    opa   = 33'(opa32);
    case (cmd.b_src)
      B_COS:   opb = 33'(cs_c);
      B_SIN:   opb = 33'(cs_s);
      B_DIST:  opb = move_dist;
      default: opb = 33'(opb32);
    endcase
  end

  // combine, round and clamp of accumulator with product
  always_comb begin
    if (cmd.sub || cmd.act == ACT_CROSS) comb_sum = 68'(acc) - 68'(prod);
    else comb_sum = 68'(acc) + 68'(prod);
    comb_sat  = sat32((comb_sum + DIR_HALF) >>> DIR_FRAC_BITS);
    cross_val = cmd.neg ? sat32(-68'(comb_sat)) : comb_sat;
    rnd_val   = (68'(prod) + DIR_HALF) >>> DIR_FRAC_BITS;
    move_val  = sat32(68'(pick(pos, cmd.comp)) + rnd_val);
  end

  // cordic step and angle fold
  always_comb begin
    xs   = cx >>> cmd.step;
    ys   = cy >>> cmd.step;
    at   = 34'(atan_entry(cmd.step));
    z32  = {in_data[15:0], 16'h0000};
    z_in = 34'(z32);
    xf   = cneg ? -cx : cx;
    yf   = cneg ? -cy : cy;
  end

  // square root trial and divider set-up
  always_comb begin
    sq_try  = sq_res + sq_bit;
    tcur    = pick(tv, cmd.comp);
    mag     = tcur[31] ? 32'(-33'(tcur)) : 32'(tcur);
    num     = (64'(mag) << DIR_FRAC_BITS) + (sq_res >> 1);
    if (dsat) div_val = dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else div_val = dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    dst_cur = sel_vec(view, right, up, tv, cmd.dst_vec);
    dst_new = place(dst_cur, cmd.comp,
                    (cmd.act == ACT_CROSS) ? cross_val : div_val);
  end

  // the root is zero exactly when the sum of squares is zero
  assign sts.n_zero = (n2 == 64'd0);

  // shared multiplier, one product per cycle
  always_ff @(posedge clk) begin
    prod <= 66'(opa * opb);
  end

  // camera state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '{z: POS_INIT, y: POS_INIT, x: POS_INIT};
      view  <= '{z: -DIR_ONE, y: 32'sd0, x: 32'sd0};
      right <= '{z: 32'sd0, y: 32'sd0, x: DIR_ONE};
      up    <= '{z: 32'sd0, y: DIR_ONE, x: 32'sd0};
    end else begin
      if (cmd.act == ACT_MOVE) pos <= place(pos, cmd.comp, move_val);
      if (cmd.act == ACT_CROSS || cmd.act == ACT_DIV_WRITE) begin
        case (cmd.dst_vec)
          VEC_VIEW:  view  <= dst_new;
          VEC_RIGHT: right <= dst_new;
          default:   up    <= dst_new;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LOAD: begin
        move_dist <= cmd.neg ? -33'($signed(in_data[47:16]))
                             : 33'($signed(in_data[47:16]));
        n2   <= 64'd0;
        cx   <= CORDIC_GAIN;
        cy   <= 34'sd0;
        if (z_in > QUARTER) begin
          cz   <= z_in - HALF_TURN;
          cneg <= 1'b1;
        end else if (z_in < -QUARTER) begin
          cz   <= z_in + HALF_TURN;
          cneg <= 1'b1;
        end else begin
          cz   <= z_in;
          cneg <= 1'b0;
        end
      end
      ACT_CORDIC: begin
        if (!cz[33]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
      end
      ACT_CS_FIN: begin
        cs_c <= 32'((xf + CS_HALF) >>> CS_SH);
        cs_s <= 32'((yf + CS_HALF) >>> CS_SH);
      end
      ACT_SAVE:  acc <= prod;
      ACT_MIX:   tv  <= place(tv, cmd.comp, comb_sat);
      ACT_SQACC: n2  <= n2 + prod[63:0];
      ACT_SQ_INIT: begin
        sq_n   <= n2;
        sq_res <= 64'd0;
        sq_bit <= 64'd1 << 62;
      end
      ACT_SQ_STEP: begin
        if (sq_n >= sq_try) begin
          sq_n   <= sq_n - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      ACT_DIV_INIT: begin
        rem  <= num;
        dv   <= sq_res << 30;
        quo  <= '0;
        dsat <= num >= (sq_res << 31);
        dneg <= tcur[31];
      end
      ACT_DIV_STEP: begin
        if (rem >= dv) begin
          rem <= rem - dv;
          quo <= {quo[29:0], 1'b1};
        end else begin
          quo <= {quo[29:0], 1'b0};
        end
        dv <= dv >> 1;
      end
      default: ;
    endcase
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= {up, right, view, pos};
  end

endmodule

[design/free_look_camera_update.sv]
// Free-look camera update: one command beat in, one 12-component state beat out.
// Rotations run 24 CORDIC steps, then the mix, the square root, one divide per
// component and the cross product, all through one shared 33x33 multiplier and
// one-bit-per-cycle root and divide units. Moves scale one direction and add it
// to the position; unused kinds change nothing. One item is in flight at a time.
// Synchronous reset restores position (100,100,100), view -z, right +x, up +y.
module free_look_camera_update
  import fluc_pkg::*;
#(
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // rotation_angle [15:0], move_distance [47:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [2:0], upper bits zero
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pos_x, pos_y, pos_z, look_x, look_y, look_z, side_x, side_y, side_z,
  // top_x, top_y, top_z, 32 bits each from bit 0 up
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  fluc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser[2:0]),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fluc_dp #(
    .DIR_FRAC_BITS (DIR_FRAC_BITS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_axis_tdata),
    .sts      (sts),
    .out_data (m_axis_tdata)
  );

endmodule

[design/fluc_chk.sv]
// port-level checks for the camera update block, bound to the top level
module fluc_chk
  import fluc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // no result beat pending right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid after reset");

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // an accepted command makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after accepting a beat");

  // a result never appears in the cycle right after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result beat raised too early");

  // ready drops only by accepting a beat
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input ready dropped without a beat");

endmodule

bind free_look_camera_update fluc_chk u_fluc_chk (.*);

[test/free_look_camera_update_tb.sv]
// testbench for the free-look camera update block: commands in, camera state checked per beat
module free_look_camera_update_tb;
  import fluc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DFB = DIR_FRAC_BITS_DEF;
  localparam int PFB = POS_FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [IN_USER_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  free_look_camera_update u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // camera state as held by the predictor
  longint cam_pos[3];
  longint cam_view[3];
  longint cam_right[3];
  longint cam_up[3];

  logic [OUT_DATA_W-1:0] expected_states[$];
  int  error_count;
  bit  idle_enable;
  longint cycle_count;

  string field_names[12] = '{"pos_x", "pos_y", "pos_z", "look_x", "look_y", "look_z",
                             "side_x", "side_y", "side_z", "top_x", "top_y", "top_z"};

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("free_look_camera_update test failed");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // cordic sine and cosine of a binary angle
  task automatic angle_sincos(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit neg;
    z = longint'($signed({ang, 16'h0000}));
    x = longint'(CORDIC_GAIN);
    y = 0;
    neg = 0;
    if (z > (longint'(1) << 30)) begin
      z -= longint'(1) << 31;
      neg = 1;
    end else if (z < -(longint'(1) << 30)) begin
      z += longint'(1) << 31;
      neg = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= longint'(atan_entry(i[4:0]));
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += longint'(atan_entry(i[4:0]));
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = round_shr(x, 30 - DFB);
    s = round_shr(y, 30 - DFB);
  endtask

  // turn a toward b, renormalize; keep dst when the mix vanishes
  task automatic turn_vector(inout longint dst[3], input longint a[3], input longint b[3],
                             input longint c, input longint s, input bit sub);
    longint t[3];
    longint unsigned n2, n, m;
    longint p, q, r;
    n2 = 0;
    for (int k = 0; k < 3; k++) begin
      p = a[k] * c;
      q = b[k] * s;
      t[k] = clamp32(round_shr(sub ? p - q : p + q, DFB));
      n2 += longint'(t[k] * t[k]);
    end
    n = int_sqrt(n2);
    if (n == 0) return;
    for (int k = 0; k < 3; k++) begin
      m = (t[k] < 0) ? -t[k] : t[k];
      r = longint'(((m << DFB) + n / 2) / n);
      dst[k] = clamp32(t[k] < 0 ? -r : r);
    end
  endtask

  task automatic cross_product(output longint dst[3], input longint a[3], input longint b[3],
                               input bit negate);
    longint v;
    int i1, i2;
    for (int k = 0; k < 3; k++) begin
      i1 = (k + 1) % 3;
      i2 = (k + 2) % 3;
      v = clamp32(round_shr(a[i1] * b[i2] - a[i2] * b[i1], DFB));
      dst[k] = negate ? clamp32(-v) : v;
    end
  endtask

  task automatic step_position(input longint dir[3], input longint d);
    for (int k = 0; k < 3; k++)
      cam_pos[k] = clamp32(cam_pos[k] + round_shr(dir[k] * d, DFB));
  endtask

  function automatic logic [OUT_DATA_W-1:0] pack_state();
    logic [OUT_DATA_W-1:0] r;
    for (int k = 0; k < 3; k++) begin
      r[32*k +: 32] = cam_pos[k][31:0];
      r[32*(3+k) +: 32] = cam_view[k][31:0];
      r[32*(6+k) +: 32] = cam_right[k][31:0];
      r[32*(9+k) +: 32] = cam_up[k][31:0];
    end
    return r;
  endfunction

  // apply one command to the predicted camera
  task automatic predict_camera(input logic [2:0] kind, input logic [15:0] ang,
                                input logic [31:0] move_dist);
    longint c, s, d, tmp[3];
    d = longint'($signed(move_dist));
    case (kind)
      KIND_PITCH: begin
        angle_sincos(ang, c, s);
        turn_vector(cam_view, cam_view, cam_up, c, s, 0);
        cross_product(tmp, cam_view, cam_right, 1);
        cam_up = tmp;
      end
      KIND_YAW: begin
        angle_sincos(ang, c, s);
        turn_vector(cam_view, cam_view, cam_right, c, s, 1);
        cross_product(tmp, cam_view, cam_up, 0);
        cam_right = tmp;
      end
      KIND_ROLL: begin
        angle_sincos(ang, c, s);
        turn_vector(cam_right, cam_right, cam_up, c, s, 0);
        cross_product(tmp, cam_view, cam_right, 1);
        cam_up = tmp;
      end
      KIND_FWD:   step_position(cam_view, -d);
      KIND_RIGHT: step_position(cam_right, d);
      KIND_UP:    step_position(cam_up, d);
      default: ;
    endcase
    expected_states.push_back(pack_state());
  endtask

  // send one command beat, with an optional idle burst first
  task automatic send_command(input logic [2:0] kind, input logic [15:0] ang,
                              input logic [31:0] move_dist);
    if (idle_enable && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {move_dist, ang};
    s_axis_tuser <= {5'b0, kind};
    predict_camera(kind, ang, move_dist);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    s_axis_tvalid <= 1'b0;
    // block is busy in the cycle after an accept
    @(posedge clk);
  endtask

  // result beat checker
  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_states.size() == 0) begin
        $error("state beat with nothing expected");
        error_count++;
      end else begin
        want = expected_states.pop_front();
        for (int k = 0; k < 12; k++)
          if (want[32*k +: 32] !== m_axis_tdata[32*k +: 32]) begin
            $error("%s expected %0d got %0d", field_names[k],
                   $signed(want[32*k +: 32]), $signed(m_axis_tdata[32*k +: 32]));
            error_count++;
          end
      end
    end
  end

  // receiver stalls
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 2048)) - 16'd1024;
      1: return 16'($urandom_range(0, 8)) + 16'h3FFC;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_distance();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0A00_0000) - 32'h0500_0000;
    endcase
  endfunction

  // extremes of angle and distance, every kind, unused kinds and operands
  task automatic test_directed();
    logic [15:0] angs[6] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h2000};
    foreach (angs[i]) send_command(KIND_PITCH, angs[i], $urandom);
    send_command(KIND_YAW, 16'h1000, 32'hFFFF_FFFF);
    send_command(KIND_ROLL, 16'hF000, 32'h0);
    send_command(KIND_YAW, 16'h8001, 32'h5555_AAAA);
    send_command(KIND_ROLL, 16'h4001, 32'h0);
    send_command(KIND_FWD, 16'hFFFF, 32'h0001_0000);
    send_command(KIND_RIGHT, 16'h1234, 32'hFFFF_0000);
    send_command(KIND_UP, 16'h0, 32'h0);
    send_command(3'd6, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(3'd7, 16'h0, 32'h0);
    // drive position into both saturation limits
    repeat (3) send_command(KIND_UP, 16'hAAAA, 32'h7FFF_FFFF);
    repeat (3) send_command(KIND_FWD, 16'h5555, 32'h7FFF_FFFF);
    repeat (3) send_command(KIND_RIGHT, 16'h0, 32'h8000_0000);
  endtask

  task automatic test_random(input int count);
    logic [2:0] kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_command(kind, rand_angle(), rand_distance());
      // halfway through, the sender holds off until every state beat is back
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    error_count = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    for (int k = 0; k < 3; k++) begin
      cam_pos[k] = longint'(100) << PFB;
      cam_view[k] = 0;
      cam_right[k] = 0;
      cam_up[k] = 0;
    end
    cam_view[2] = -(longint'(1) << DFB);
    cam_right[0] = longint'(1) << DFB;
    cam_up[1] = longint'(1) << DFB;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(1500);
    idle_enable = 1'b0;
    test_random(280);

    wait_drained();
    repeat (400) @(posedge clk);
    if (error_count == 0 && expected_states.size() == 0) begin
      $display("free_look_camera_update test passed");
    end else begin
      $display("free_look_camera_update test failed");
    end
    $finish;
  end
endmodule
